/* sv/arxdp_pkg.sv */
// ----------------------------------------------------------------------------
// arxdp_pkg
// Types, request codes and defaults shared by the ARX difference predictor.
// ----------------------------------------------------------------------------
`default_nettype none
package arxdp_pkg;

  localparam int CHANNELS_DEF   = 4;
  localparam int DELAY_TAPS_DEF = 15;
  localparam int SAMPLE_INPUTS  = 4;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_INIT   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic signed [63:0] PRED_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] PRED_MIN = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic [1:0]         coef_channel;
    logic [3:0]         coef_delay;
    logic signed [31:0] coef_value;
  } req_t;

  typedef struct packed {
    logic signed [47:0] predicted_value;
    logic               saturated;
    logic               status;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic init;
    logic clear;
    logic load;
    logic rotate;
    logic mul;
  } lane_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MERGE,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

/* sv/arxdp_lane.sv */
// ----------------------------------------------------------------------------
// arxdp_lane
// One channel: sample history ring, tap ring and a multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none
module arxdp_lane
  import arxdp_pkg::*;
#(
  parameter int DELAY_TAPS = DELAY_TAPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lane_ctl_t          ctl,
  input  wire logic signed [31:0] sample,
  input  wire logic               coef_sel,
  input  wire logic [3:0]         coef_delay,
  input  wire logic signed [31:0] coef_value,
  output logic signed [31:0]      newest,
  output logic signed [63:0]      acc
);

  localparam int HD = DELAY_TAPS + 2;
  localparam int TIW = (DELAY_TAPS > 1) ? $clog2(DELAY_TAPS) : 1;

  logic signed [31:0] hist [HD];
  logic signed [31:0] taps [DELAY_TAPS];
  logic signed [64:0] prod;
  logic               prod_v;
  logic signed [32:0] diff;
  logic signed [64:0] prod_r;
  logic signed [48:0] rnd;
  logic [3:0]         dm1;
  logic [TIW-1:0]     tidx;
  logic               tap_wr;
  logic signed [32:0] tsum;
  logic signed [31:0] tsat;

  assign newest = hist[0];
  assign diff   = {hist[1][31], hist[1]} - {hist[2][31], hist[2]};
  assign prod_r = prod + 65'sd32768;
  assign rnd    = prod_r[64:16];
  assign dm1    = coef_delay - 4'd1;
  assign tidx   = TIW'(dm1);
  assign tap_wr = ctl.load && coef_sel && (coef_delay != 4'd0)
                  && ({2'b00, coef_delay} <= 6'(DELAY_TAPS));
  assign tsum   = {taps[tidx][31], taps[tidx]} + {coef_value[31], coef_value};

  always_comb begin
    if (tsum > 33'sh0_7FFF_FFFF) begin
      tsat = 32'sh7FFF_FFFF;
    end else if (tsum < -33'sh0_8000_0000) begin
      tsat = -32'sh8000_0000;
    end else begin
      tsat = tsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HD; i++) hist[i] <= '0;
    end else if (ctl.init) begin
      for (int i = 0; i < HD; i++) hist[i] <= sample;
    end else if (ctl.push) begin
      hist[0] <= sample;
      for (int i = 1; i < HD; i++) hist[i] <= hist[i-1];
    end else if (ctl.rotate) begin
      for (int i = 0; i < HD - 1; i++) hist[i] <= hist[i+1];
      hist[HD-1] <= hist[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < DELAY_TAPS; i++) taps[i] <= '0;
    end else if (tap_wr) begin
      taps[tidx] <= tsat;
    end else if (ctl.mul) begin
      for (int i = 0; i < DELAY_TAPS - 1; i++) taps[i] <= taps[i+1];
      taps[DELAY_TAPS-1] <= taps[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.mul;
    end
    prod <= diff * taps[0];
    if (ctl.push) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + 64'(rnd);
    end
  end

endmodule
`default_nettype wire

/* sv/arx_difference_predictor.sv */
// ----------------------------------------------------------------------------
// arx_difference_predictor
// Multi-channel ARX predictor in incremental form with per-channel lanes.
// ----------------------------------------------------------------------------
// A sample item passes through the run, merge and result states: every lane
// walks its history ring once, one tap product per cycle, then the lane sums
// are merged one lane per cycle. A coefficient item goes from idle straight to
// the result state; initialize and clear items are done in idle. A finished
// result waits in the output register while the next item is taken.
`default_nettype none
module arx_difference_predictor
  import arxdp_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int DELAY_TAPS = DELAY_TAPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output rsp_t            rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_data
);

  localparam int HD  = DELAY_TAPS + 2;
  localparam int KW  = $clog2(HD);
  localparam int LIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t             state, state_next;
  lane_ctl_t          ctl;
  logic [KW-1:0]      k;
  logic [LIW-1:0]     midx;
  logic signed [63:0] sum;
  logic               res_coef;
  logic               res_status;
  logic [2:0]         active_channels;
  logic [3:0]         ncnt;
  logic               accept;
  logic               load_out;
  logic               sat_hi, sat_lo;
  logic signed [31:0] smp [SAMPLE_INPUTS];
  logic signed [31:0] lane_sample [CHANNELS];
  logic signed [31:0] lane_newest [CHANNELS];
  logic signed [63:0] lane_acc [CHANNELS];

  assign smp[0]    = req.sample_0;
  assign smp[1]    = req.sample_1;
  assign smp[2]    = req.sample_2;
  assign smp[3]    = req.sample_3;
  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign load_out  = (state == ST_RESULT) && (!rsp_valid || !rsp_stall);
  assign sat_hi    = sum > PRED_MAX;
  assign sat_lo    = sum < PRED_MIN;

  always_comb begin
    if (active_channels == 3'd0) begin
      ncnt = 4'd1;
    end else if ({1'b0, active_channels} > 4'(CHANNELS)) begin
      ncnt = 4'(CHANNELS);
    end else begin
      ncnt = {1'b0, active_channels};
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    if (c < SAMPLE_INPUTS) begin : g_in
      assign lane_sample[c] = smp[c];
    end else begin : g_zero
      assign lane_sample[c] = '0;
    end
    arxdp_lane #(.DELAY_TAPS(DELAY_TAPS)) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sample     (lane_sample[c]),
      .coef_sel   (req.coef_channel == 2'(c)),
      .coef_delay (req.coef_delay),
      .coef_value (req.coef_value),
      .newest     (lane_newest[c]),
      .acc        (lane_acc[c])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.req_type == REQ_SAMPLE) begin
          state_next = ST_RUN;
        end else if (accept && req.req_type == REQ_COEF) begin
          state_next = ST_RESULT;
        end
      end
      ST_RUN: begin
        if (k == KW'(HD - 1)) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (midx == LIW'(CHANNELS - 1)) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != ST_IDLE);
    ctl.push   = accept && (req.req_type == REQ_SAMPLE);
    ctl.init   = accept && (req.req_type == REQ_INIT);
    ctl.clear  = accept && (req.req_type == REQ_CLEAR);
    ctl.load   = accept && (req.req_type == REQ_COEF);
    ctl.rotate = (state == ST_RUN);
    ctl.mul    = (state == ST_RUN) && (k < KW'(DELAY_TAPS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      active_channels <= 3'd1;
      rsp_valid       <= 1'b0;
      k               <= '0;
      midx            <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) active_channels <= cfg_data;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      k    <= (state == ST_RUN) ? k + KW'(1) : '0;
      midx <= (state == ST_MERGE) ? midx + LIW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_coef   <= (req.req_type == REQ_COEF);
      res_status <= (req.coef_delay == 4'd0);
    end
    if (ctl.push) begin
      sum <= 64'(lane_newest[0]);
    end else if (state == ST_MERGE && ({{(4 - LIW){1'b0}}, midx} < ncnt)) begin
      sum <= sum + lane_acc[midx];
    end
    if (load_out) begin
      if (res_coef) begin
        rsp.predicted_value <= '0;
        rsp.saturated       <= 1'b0;
        rsp.status          <= res_status;
      end else begin
        rsp.predicted_value <= sat_hi ? PRED_MAX[47:0] : (sat_lo ? PRED_MIN[47:0] : sum[47:0]);
        rsp.saturated       <= sat_hi || sat_lo;
        rsp.status          <= 1'b0;
      end
    end
  end

  a_sample_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_SAMPLE) |=> state == ST_RUN)
    else $error("sample item did not start the lane walk");

  a_valid_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_RESULT))
    else $error("result appeared without a result state");

  a_coef_result_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status) |-> (rsp.predicted_value == '0 && !rsp.saturated))
    else $error("rejected load carries a prediction");

  a_merge_after_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MERGE && $past(state) != ST_MERGE) |-> $past(k) == KW'(HD - 1))
    else $error("merge began before the walk finished");

endmodule
`default_nettype wire

/* verif/arx_difference_predictor_test.sv */
// ----------------------------------------------------------------------------
// arx_difference_predictor_test
// Self-checking bench for the ARX difference predictor. A driver sends request
// items from a queue, a monitor checks every response against a behavioral
// predictor of the history, the tap table and the channel count.
// ----------------------------------------------------------------------------
module arx_difference_predictor_test;
  import arxdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 4;
  localparam int MAXD = 15;
  localparam int DEPTH = MAXD + 2;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = 3'd1;

  arx_difference_predictor DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic signed [31:0] history[NCH][DEPTH];
  logic signed [31:0] taps[NCH][MAXD];
  logic [2:0] channel_count;

  req_t pending_items[$];
  rsp_t expected_rsps[$];
  int failures = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  bit req_taken = 1'b0;

  function automatic logic signed [63:0] round_to_q16(logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic rsp_t predict_rsp(req_t r, output bit has_rsp);
    rsp_t o;
    logic signed [63:0] acc, diff, s;
    logic signed [31:0] v;
    int n;
    o = '0;
    has_rsp = 1'b0;
    case (r.req_type)
      REQ_SAMPLE: begin
        for (int c = 0; c < NCH; c++) begin
          for (int d = DEPTH - 1; d > 0; d--) history[c][d] = history[c][d - 1];
        end
        history[0][0] = r.sample_0;
        history[1][0] = r.sample_1;
        history[2][0] = r.sample_2;
        history[3][0] = r.sample_3;
        n = (channel_count == 0) ? 1 : (channel_count > NCH) ? NCH : channel_count;
        acc = 64'(history[0][1]);
        for (int c = 0; c < n; c++) begin
          for (int d = 1; d <= MAXD; d++) begin
            diff = 64'(history[c][d]) - 64'(history[c][d + 1]);
            acc += round_to_q16(diff * 64'(taps[c][d - 1]));
          end
        end
        if (acc > PRED_MAX) begin
          acc = PRED_MAX;
          o.saturated = 1'b1;
        end else if (acc < PRED_MIN) begin
          acc = PRED_MIN;
          o.saturated = 1'b1;
        end
        o.predicted_value = acc[47:0];
        has_rsp = 1'b1;
      end
      REQ_COEF: begin
        if (r.coef_delay == 0) begin
          o.status = 1'b1;
        end else begin
          s = 64'(taps[r.coef_channel][r.coef_delay - 1]) + 64'(r.coef_value);
          if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
          if (s < -64'sh8000_0000) s = -64'sh8000_0000;
          taps[r.coef_channel][r.coef_delay - 1] = s[31:0];
        end
        has_rsp = 1'b1;
      end
      REQ_INIT: begin
        for (int c = 0; c < NCH; c++) begin
          v = (c == 0) ? r.sample_0 : (c == 1) ? r.sample_1 :
              (c == 2) ? r.sample_2 : r.sample_3;
          for (int d = 0; d < DEPTH; d++) history[c][d] = v;
        end
      end
      default: begin
        for (int c = 0; c < NCH; c++) begin
          for (int d = 0; d < MAXD; d++) taps[c][d] = '0;
        end
      end
    endcase
    return o;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_taken) begin
        if (pending_items.size() > 0 && !hold_off && (calm || $urandom_range(99) >= 21)) begin
          req <= pending_items.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    rsp_t got;
    bit has_rsp;
    if (!rst) begin
      req_taken <= req_valid && !req_stall;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (req_valid && !req_stall) begin
        exp_rsp = predict_rsp(req, has_rsp);
        if (has_rsp) expected_rsps = {expected_rsps, exp_rsp};
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (expected_rsps.size() == 0) begin
          $error("unexpected item: predicted_value %h", got.predicted_value);
          failures++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got.predicted_value !== exp_rsp.predicted_value) begin
            $error("predicted_value expected %h actual %h",
                   exp_rsp.predicted_value, got.predicted_value);
            failures++;
          end
          if (got.saturated !== exp_rsp.saturated) begin
            $error("saturated expected %b actual %b", exp_rsp.saturated, got.saturated);
            failures++;
          end
          if (got.status !== exp_rsp.status) begin
            $error("status expected %b actual %b", exp_rsp.status, got.status);
            failures++;
          end
        end
      end
      if (quiet_cycles > IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(65536 * 4))) - 32'sd131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_item(logic [1:0] kind);
    req_t r;
    r.req_type = kind;
    r.sample_0 = rand_sample();
    r.sample_1 = rand_sample();
    r.sample_2 = rand_sample();
    r.sample_3 = rand_sample();
    r.coef_channel = 2'($urandom_range(3));
    r.coef_delay = 4'($urandom_range(15));
    r.coef_value = ($urandom_range(3) == 0) ? $urandom :
                   $signed(32'($urandom_range(131072))) - 32'sd65536;
    return r;
  endfunction

  task automatic queue_item(req_t r);
    pending_items = {pending_items, r};
  endtask

  task automatic drain_and_wait();
    while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [2:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    channel_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    req_t r;
    logic [2:0] counts[6] = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd1};
    for (int c = 0; c < NCH; c++) begin
      for (int d = 0; d < DEPTH; d++) history[c][d] = '0;
      for (int d = 0; d < MAXD; d++) taps[c][d] = '0;
    end
    channel_count = 3'd1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_count(3'd4);

    // Directed items: zero delay, extreme taps, accumulation to saturation.
    r = make_item(REQ_INIT);
    r.sample_0 = 32'sh7FFF_FFFF; r.sample_1 = 32'sh8000_0000;
    r.sample_2 = '0; r.sample_3 = 32'sh0001_0000;
    queue_item(r);
    r = make_item(REQ_COEF); r.coef_delay = 4'd0; queue_item(r);
    for (int c = 0; c < NCH; c++) begin
      r = make_item(REQ_COEF); r.coef_channel = 2'(c); r.coef_delay = 4'd1;
      r.coef_value = 32'sh7FFF_FFFF; queue_item(r);
      queue_item(r);
      r.coef_delay = 4'd15; r.coef_value = 32'sh8000_0000;
      queue_item(r);
      queue_item(r);
    end
    for (int i = 0; i < 3; i++) begin
      r = make_item(REQ_SAMPLE);
      r.sample_0 = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      r.sample_1 = ~r.sample_0; r.sample_2 = r.sample_0; r.sample_3 = ~r.sample_0;
      queue_item(r);
    end
    queue_item(make_item(REQ_CLEAR));
    queue_item(make_item(REQ_SAMPLE));
    drain_and_wait();

    for (int phase = 0; phase < 6; phase++) begin
      write_count(counts[phase]);
      calm = (phase == 2);
      for (int i = 0; i < 135; i++) begin
        case ($urandom_range(19))
          0: queue_item(make_item(REQ_CLEAR));
          1: queue_item(make_item(REQ_INIT));
          2, 3, 4, 5, 6, 7: queue_item(make_item(REQ_COEF));
          default: queue_item(make_item(REQ_SAMPLE));
        endcase
        if (phase == 4 && i == 60) begin
          while (pending_items.size() > 0 || req_valid) @(posedge clk);
          hold_off = 1'b1;
          while (expected_rsps.size() > 0) @(posedge clk);
          hold_off = 1'b0;
        end
      end
      drain_and_wait();
    end
    calm = 1'b0;

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/arxdp_pkg.sv
sv/arxdp_lane.sv
sv/arx_difference_predictor.sv
verif/arx_difference_predictor_test.sv
